[rtl/adts_pkg.sv]
package adts_pkg;

    localparam int MAX_FRAME_LENGTH_DEF = 8191;
    localparam int LEN_W                = 13;

    localparam logic [7:0] SYNC_BYTE   = 8'hFF;
    localparam logic [3:0] SYNC_NIBBLE = 4'hF;

    localparam logic [3:0] HDR_SIZE_NOCRC   = 4'd7;
    localparam logic [3:0] HDR_SIZE_CRC     = 4'd9;
    localparam logic [3:0] MAX_RATE_INDEX   = 4'd11;
    localparam logic [1:0] PROFILE_RESERVED = 2'd3;
    localparam logic [1:0] CRC_BYTES        = 2'd2;

    localparam logic [1:0] CMD_DATA      = 2'd0;
    localparam logic [1:0] CMD_CLEAR     = 2'd1;
    localparam logic [1:0] CMD_CLEAR_ALL = 2'd2;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_ERROR   = 1'b1;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_NO_SYNC    = 3'd1;
    localparam logic [2:0] ERR_LOST_SYNC  = 3'd2;
    localparam logic [2:0] ERR_BAD_FORMAT = 3'd3;
    localparam logic [2:0] ERR_MULTI_RAW  = 3'd4;
    localparam logic [2:0] ERR_BAD_LENGTH = 3'd5;

    typedef struct packed {
        logic       kind;
        logic [2:0] error_code;
        logic [7:0] payload_byte;
        logic       frame_last;
        logic [1:0] audio_profile;
        logic [3:0] rate_index;
        logic [2:0] channel_count;
    } t_result;

endpackage

[rtl/adts_parser.sv]
module adts_parser #(
    parameter int MAX_FRAME_LENGTH = adts_pkg::MAX_FRAME_LENGTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_command,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_chunk,
    output logic              o_res_valid,
    output adts_pkg::t_result o_res
);

    localparam int LEFT_W = $clog2(MAX_FRAME_LENGTH + 1);

    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_CRC     = 2'd2;
    localparam logic [1:0] PH_PAYLOAD = 2'd3;

    localparam logic [2:0] HDR_LAST_IDX = 3'd6;

    logic [1:0]        r_phase, n_phase;
    logic [7:0]        r_hist0, n_hist0;
    logic [7:0]        r_hist1, n_hist1;
    logic [7:0]        r_hdr [6];
    logic [2:0]        r_hcount, n_hcount;
    logic [1:0]        r_crc, n_crc;
    logic [LEFT_W-1:0] r_left, n_left;
    logic              r_chunk_start, n_chunk_start;
    logic              r_fmt_latched, n_fmt_latched;
    logic [1:0]        r_profile, n_profile;
    logic [3:0]        r_rate, n_rate;
    logic [2:0]        r_chans, n_chans;

    logic                        hunt_load;
    logic                        hdr_we;
    logic [2:0]                  hunt_cnt;
    logic                        hunt_match;
    logic                        absent;
    logic [1:0]                  f_profile;
    logic [3:0]                  f_rate;
    logic [2:0]                  f_chans;
    logic [adts_pkg::LEN_W-1:0]  f_length;
    logic [3:0]                  hsize;
    logic                        sync_ok;
    logic                        fmt_bad;
    logic                        len_bad;
    logic [LEFT_W-1:0]           left_calc;
    logic                        res_valid;
    logic                        res_kind;
    logic [2:0]                  res_code;
    logic                        res_last;

    assign hunt_cnt   = r_chunk_start ? 3'd0 : r_hcount;
    assign hunt_match = (hunt_cnt == 3'd2) && (r_hist0 == adts_pkg::SYNC_BYTE)
                        && (r_hist1[7:4] == adts_pkg::SYNC_NIBBLE)
                        && (r_hist1[2:1] == 2'd0)
                        && !(r_hist1[3]
                             && (i_data_byte[7:6] == adts_pkg::PROFILE_RESERVED));

    assign absent    = r_hdr[1][0];
    assign f_profile = r_hdr[2][7:6];
    assign f_rate    = r_hdr[2][5:2];
    assign f_chans   = {r_hdr[2][0], r_hdr[3][7:6]};
    assign f_length  = {r_hdr[3][1:0], r_hdr[4], r_hdr[5][7:5]};
    assign hsize     = absent ? adts_pkg::HDR_SIZE_NOCRC : adts_pkg::HDR_SIZE_CRC;
    assign sync_ok   = (r_hdr[0] == adts_pkg::SYNC_BYTE)
                       && (r_hdr[1][7:4] == adts_pkg::SYNC_NIBBLE);
    assign fmt_bad   = (f_profile == adts_pkg::PROFILE_RESERVED) || (f_chans == 3'd0)
                       || (f_rate > adts_pkg::MAX_RATE_INDEX);
    assign len_bad   = (f_length < {{(adts_pkg::LEN_W-4){1'b0}}, hsize})
                       || (f_length > adts_pkg::LEN_W'(MAX_FRAME_LENGTH));
    assign left_calc = LEFT_W'(f_length - {{(adts_pkg::LEN_W-4){1'b0}}, hsize});

    always_comb begin
        n_phase       = r_phase;
        n_hist0       = r_hist0;
        n_hist1       = r_hist1;
        n_hcount      = r_hcount;
        n_crc         = r_crc;
        n_left        = r_left;
        n_chunk_start = r_chunk_start;
        n_fmt_latched = r_fmt_latched;
        n_profile     = r_profile;
        n_rate        = r_rate;
        n_chans       = r_chans;
        hunt_load     = 1'b0;
        hdr_we        = 1'b0;
        res_valid     = 1'b0;
        res_kind      = adts_pkg::KIND_ERROR;
        res_code      = adts_pkg::ERR_NONE;
        res_last      = 1'b0;

        if (i_accept) begin
            if ((i_command == adts_pkg::CMD_CLEAR) || (i_command == adts_pkg::CMD_CLEAR_ALL)) begin
                n_phase       = PH_HUNT;
                n_hcount      = 3'd0;
                n_crc         = 2'd0;
                n_left        = '0;
                n_chunk_start = 1'b1;
                if (i_command == adts_pkg::CMD_CLEAR_ALL) begin
                    n_fmt_latched = 1'b0;
                    n_profile     = 2'd0;
                    n_rate        = 4'd0;
                    n_chans       = 3'd0;
                end
            end else if (i_command == adts_pkg::CMD_DATA) begin
                n_chunk_start = i_end_of_chunk;
                unique case (r_phase)
                    PH_HUNT: begin
                        if (hunt_match) begin
                            hunt_load = 1'b1;
                            n_hcount  = 3'd3;
                            n_phase   = PH_HEADER;
                        end else begin
                            // fill history, then slide it
                            if (hunt_cnt == 3'd0) begin
                                n_hist0  = i_data_byte;
                                n_hcount = 3'd1;
                            end else if (hunt_cnt == 3'd1) begin
                                n_hist1  = i_data_byte;
                                n_hcount = 3'd2;
                            end else begin
                                n_hist0  = r_hist1;
                                n_hist1  = i_data_byte;
                                n_hcount = hunt_cnt;
                            end
                            if (i_end_of_chunk) begin
                                n_hcount  = 3'd0;
                                res_valid = 1'b1;
                                res_code  = adts_pkg::ERR_NO_SYNC;
                            end
                        end
                    end
                    PH_HEADER: begin
                        if (r_hcount == 3'd7) begin
                            n_phase  = PH_HUNT;
                            n_hcount = 3'd0;
                        end else if (r_hcount != HDR_LAST_IDX) begin
                            hdr_we   = 1'b1;
                            n_hcount = r_hcount + 3'd1;
                        end else begin
                            n_hcount = 3'd7;
                            if (sync_ok && !r_fmt_latched && !fmt_bad) begin
                                n_fmt_latched = 1'b1;
                                n_profile     = f_profile;
                                n_rate        = f_rate;
                                n_chans       = f_chans;
                            end
                            priority if (!sync_ok) begin
                                res_code = adts_pkg::ERR_LOST_SYNC;
                            end else if (!r_fmt_latched && fmt_bad) begin
                                res_code = adts_pkg::ERR_BAD_FORMAT;
                            end else if (i_data_byte[1:0] != 2'd0) begin
                                res_code = adts_pkg::ERR_MULTI_RAW;
                            end else if (len_bad) begin
                                res_code = adts_pkg::ERR_BAD_LENGTH;
                            end else begin
                                res_code = adts_pkg::ERR_NONE;
                            end
                            if (res_code != adts_pkg::ERR_NONE) begin
                                // drop the header, keep hunting in this chunk
                                res_valid = 1'b1;
                                n_phase   = PH_HUNT;
                                n_hcount  = 3'd0;
                            end else begin
                                n_left = left_calc;
                                if (!absent) begin
                                    n_phase = PH_CRC;
                                    n_crc   = adts_pkg::CRC_BYTES;
                                end else if (left_calc == '0) begin
                                    n_phase  = i_end_of_chunk ? PH_HUNT : PH_HEADER;
                                    n_hcount = 3'd0;
                                end else begin
                                    n_phase = PH_PAYLOAD;
                                end
                            end
                        end
                    end
                    PH_CRC: begin
                        n_crc = (r_crc != 2'd0) ? r_crc - 2'd1 : 2'd0;
                        if (n_crc == 2'd0) begin
                            if (r_left == '0) begin
                                n_phase  = i_end_of_chunk ? PH_HUNT : PH_HEADER;
                                n_hcount = 3'd0;
                            end else begin
                                n_phase = PH_PAYLOAD;
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        n_left    = (r_left != '0) ? r_left - LEFT_W'(1) : '0;
                        res_valid = 1'b1;
                        res_kind  = adts_pkg::KIND_PAYLOAD;
                        if (n_left == '0) begin
                            res_last = 1'b1;
                            n_phase  = i_end_of_chunk ? PH_HUNT : PH_HEADER;
                            n_hcount = 3'd0;
                        end
                    end
                    default: begin
                        n_phase = PH_HUNT;
                    end
                endcase
            end
        end
    end

    assign o_res_valid          = res_valid;
    assign o_res.kind           = res_kind;
    assign o_res.error_code     = res_code;
    assign o_res.payload_byte   = (res_kind == adts_pkg::KIND_PAYLOAD) ? i_data_byte : 8'd0;
    assign o_res.frame_last     = res_last;
    assign o_res.audio_profile  = n_profile;
    assign o_res.rate_index     = n_rate;
    assign o_res.channel_count  = n_chans;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HUNT;
            r_hist0       <= 8'd0;
            r_hist1       <= 8'd0;
            r_hcount      <= 3'd0;
            r_crc         <= 2'd0;
            r_left        <= '0;
            r_chunk_start <= 1'b1;
            r_fmt_latched <= 1'b0;
            r_profile     <= 2'd0;
            r_rate        <= 4'd0;
            r_chans       <= 3'd0;
        end else begin
            r_phase       <= n_phase;
            r_hist0       <= n_hist0;
            r_hist1       <= n_hist1;
            r_hcount      <= n_hcount;
            r_crc         <= n_crc;
            r_left        <= n_left;
            r_chunk_start <= n_chunk_start;
            r_fmt_latched <= n_fmt_latched;
            r_profile     <= n_profile;
            r_rate        <= n_rate;
            r_chans       <= n_chans;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hunt_load) begin
            r_hdr[0] <= r_hist0;
            r_hdr[1] <= r_hist1;
            r_hdr[2] <= i_data_byte;
        end else if (hdr_we) begin
            r_hdr[r_hcount] <= i_data_byte;
        end
    end

endmodule

[rtl/adts_out_buf.sv]
module adts_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  adts_pkg::t_result i_res,
    input  logic              i_stall,
    output logic              o_valid,
    output adts_pkg::t_result o_res,
    output logic              o_stall
);

    logic              r_out_valid;
    adts_pkg::t_result r_out;
    logic              r_skid_valid;
    adts_pkg::t_result r_skid;
    logic              out_take;

    assign out_take = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // input side is stalled; drain the skid word first
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || out_take) begin
            r_out_valid <= i_res_valid;
        end else if (i_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || out_take) begin
            if (i_res_valid) begin
                r_out <= i_res;
            end
        end else if (i_res_valid) begin
            r_skid <= i_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign o_stall = r_skid_valid;

endmodule

[rtl/adts_aac_deframer.sv]
// ADTS AAC deframer: takes one stream byte (or a clear command) per cycle while
// o_stall is low and returns payload bytes and error reports from an output
// register. All parsing is one state update per byte, so the block sustains
// one byte per clock while o_stall is low. A two-word output buffer (output
// register plus skid word) lets it keep taking bytes while a result waits;
// o_stall rises only when both words are held and drops as soon as the output
// side takes one. No clearing pass is needed after reset.
module adts_aac_deframer #(
    parameter int MAX_FRAME_LENGTH = adts_pkg::MAX_FRAME_LENGTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_command,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_chunk,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_kind,
    output logic [2:0] o_error_code,
    output logic [7:0] o_payload_byte,
    output logic       o_frame_last,
    output logic [1:0] o_audio_profile,
    output logic [3:0] o_rate_index,
    output logic [2:0] o_channel_count
);

    logic              accept;
    logic              res_valid;
    adts_pkg::t_result res;
    adts_pkg::t_result out_res;

    assign accept = i_valid && !o_stall;

    adts_parser #(
        .MAX_FRAME_LENGTH(MAX_FRAME_LENGTH)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_command      (i_command),
        .i_data_byte    (i_data_byte),
        .i_end_of_chunk (i_end_of_chunk),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    adts_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_res       (out_res),
        .o_stall     (o_stall)
    );

    assign o_kind          = out_res.kind;
    assign o_error_code    = out_res.error_code;
    assign o_payload_byte  = out_res.payload_byte;
    assign o_frame_last    = out_res.frame_last;
    assign o_audio_profile = out_res.audio_profile;
    assign o_rate_index    = out_res.rate_index;
    assign o_channel_count = out_res.channel_count;

endmodule

[rtl/adts_checker.sv]
module adts_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [1:0] i_command,
    input logic [7:0] i_data_byte,
    input logic       i_end_of_chunk,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_kind,
    input logic [2:0] o_error_code,
    input logic [7:0] o_payload_byte,
    input logic       o_frame_last,
    input logic [1:0] o_audio_profile,
    input logic [3:0] o_rate_index,
    input logic [2:0] o_channel_count
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_error_code)
            && $stable(o_payload_byte) && $stable(o_frame_last))
        else $error("stalled result word changed");

    a_payload_no_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == adts_pkg::KIND_PAYLOAD) |-> o_error_code == adts_pkg::ERR_NONE)
        else $error("payload word carries an error code");

    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == adts_pkg::KIND_ERROR) |->
            (o_payload_byte == 8'd0) && !o_frame_last
            && (o_error_code != adts_pkg::ERR_NONE) && (o_error_code <= adts_pkg::ERR_BAD_LENGTH))
        else $error("malformed error report");

    // payload only flows after a good header has latched a format
    a_payload_has_format: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == adts_pkg::KIND_PAYLOAD) |->
            (o_channel_count != 3'd0) && (o_rate_index <= adts_pkg::MAX_RATE_INDEX))
        else $error("payload word without a latched format");

endmodule

bind adts_aac_deframer adts_checker u_adts_checker (.*);

[sim/adts_aac_deframer_test.sv]
`timescale 1ns / 1ps

import adts_pkg::*;

typedef enum logic [1:0] {
    ST_HUNT,
    ST_HEADER,
    ST_CRC,
    ST_PAYLOAD
} t_parse_state;

class adts_deframe_predictor;
    t_parse_state state;
    logic [7:0]   hist [2];
    logic [7:0]   hdr [7];
    logic [3:0]   hcount;
    logic [1:0]   crc_left;
    logic [12:0]  pay_left;
    logic         chunk_start;
    logic         fmt_valid;
    logic [8:0]   fmt;
    t_result      due_outputs [$];
    int           failures;

    function new();
        state       = ST_HUNT;
        hist[0]     = '0;
        hist[1]     = '0;
        foreach (hdr[i]) hdr[i] = '0;
        hcount      = '0;
        crc_left    = '0;
        pay_left    = '0;
        chunk_start = 1'b1;
        fmt_valid   = 1'b0;
        fmt         = '0;
        failures    = 0;
    endfunction

    function void flag(string msg);
        failures++;
        if (failures <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function void restart_hunt();
        state  = ST_HUNT;
        hcount = '0;
    endfunction

    function void frame_end(logic eoc);
        if (eoc) begin
            restart_hunt();
        end else begin
            state  = ST_HEADER;
            hcount = '0;
        end
    endfunction

    function void push_output(logic kind, logic [2:0] code, logic [7:0] b, logic last);
        t_result r;
        r.kind          = kind;
        r.error_code    = code;
        r.payload_byte  = b;
        r.frame_last    = last;
        r.audio_profile = fmt[8:7];
        r.rate_index    = fmt[6:3];
        r.channel_count = fmt[2:0];
        due_outputs.insert(due_outputs.size(), r);
    endfunction

    function logic [2:0] parse_header(logic eoc);
        logic        absent;
        logic [1:0]  prof;
        logic [3:0]  rate;
        logic [2:0]  chans;
        logic [12:0] length;
        logic [3:0]  hsize;
        absent = hdr[1][0];
        prof   = hdr[2][7:6];
        rate   = hdr[2][5:2];
        chans  = {hdr[2][0], hdr[3][7:6]};
        length = {hdr[3][1:0], hdr[4], hdr[5][7:5]};
        hsize  = absent ? HDR_SIZE_NOCRC : HDR_SIZE_CRC;
        if (hdr[0] != SYNC_BYTE || hdr[1][7:4] != SYNC_NIBBLE) return ERR_LOST_SYNC;
        if (!fmt_valid) begin
            if (prof == PROFILE_RESERVED || chans == 3'd0 || rate > MAX_RATE_INDEX)
                return ERR_BAD_FORMAT;
            fmt_valid = 1'b1;
            fmt       = {prof, rate, chans};
        end
        if (hdr[6][1:0] != 2'd0) return ERR_MULTI_RAW;
        if (length < hsize || int'(length) > MAX_FRAME_LENGTH_DEF) return ERR_BAD_LENGTH;
        pay_left = length - hsize;
        if (!absent) begin
            state    = ST_CRC;
            crc_left = CRC_BYTES;
        end else if (pay_left == 13'd0) begin
            frame_end(eoc);
        end else begin
            state = ST_PAYLOAD;
        end
        return ERR_NONE;
    endfunction

    function void take_word(logic [1:0] cmd, logic [7:0] b, logic eoc);
        logic       first;
        logic [2:0] err;
        first = chunk_start;
        if (cmd == CMD_CLEAR || cmd == CMD_CLEAR_ALL) begin
            restart_hunt();
            crc_left    = '0;
            pay_left    = '0;
            chunk_start = 1'b1;
            if (cmd == CMD_CLEAR_ALL) begin
                fmt_valid = 1'b0;
                fmt       = '0;
            end
            return;
        end
        if (cmd != CMD_DATA) return;
        chunk_start = eoc;
        case (state)
            ST_HUNT: begin
                if (first) hcount = '0;
                if (hcount >= 4'd2 && hist[0] == SYNC_BYTE && hist[1][7:4] == SYNC_NIBBLE
                        && hist[1][2:1] == 2'd0
                        && !(hist[1][3] && b[7:6] == PROFILE_RESERVED)) begin
                    hdr[0] = hist[0];
                    hdr[1] = hist[1];
                    hdr[2] = b;
                    hcount = 4'd3;
                    state  = ST_HEADER;
                    return;
                end
                if (hcount < 4'd2) begin
                    hist[hcount[0]] = b;
                    hcount++;
                end else begin
                    hist[0] = hist[1];
                    hist[1] = b;
                end
                if (eoc) begin
                    hcount = '0;
                    push_output(KIND_ERROR, ERR_NO_SYNC, 8'd0, 1'b0);
                end
            end
            ST_HEADER: begin
                if (hcount >= 4'd7) begin
                    restart_hunt();
                    return;
                end
                hdr[hcount] = b;
                hcount++;
                if (hcount == 4'd7) begin
                    err = parse_header(eoc);
                    if (err != ERR_NONE) begin
                        restart_hunt();
                        push_output(KIND_ERROR, err, 8'd0, 1'b0);
                    end
                end
            end
            ST_CRC: begin
                if (crc_left != 2'd0) crc_left--;
                if (crc_left == 2'd0) begin
                    if (pay_left == 13'd0) frame_end(eoc);
                    else state = ST_PAYLOAD;
                end
            end
            default: begin
                if (pay_left != 13'd0) pay_left--;
                if (pay_left == 13'd0) begin
                    frame_end(eoc);
                    push_output(KIND_PAYLOAD, ERR_NONE, b, 1'b1);
                end else begin
                    push_output(KIND_PAYLOAD, ERR_NONE, b, 1'b0);
                end
            end
        endcase
    endfunction

    function void match_output(t_result got);
        t_result want;
        if (due_outputs.size() == 0) begin
            flag($sformatf("unexpected output word: kind=%0d code=%0d byte=%02h last=%0d",
                           got.kind, got.error_code, got.payload_byte, got.frame_last));
            return;
        end
        want = due_outputs.pop_front();
        if (got.kind !== want.kind || got.error_code !== want.error_code
                || got.payload_byte !== want.payload_byte
                || got.frame_last !== want.frame_last
                || got.audio_profile !== want.audio_profile
                || got.rate_index !== want.rate_index
                || got.channel_count !== want.channel_count)
            flag($sformatf({"output word mismatch: expected kind=%0d code=%0d byte=%02h ",
                            "last=%0d fmt=%0d/%0d/%0d, got kind=%0d code=%0d byte=%02h ",
                            "last=%0d fmt=%0d/%0d/%0d"},
                           want.kind, want.error_code, want.payload_byte, want.frame_last,
                           want.audio_profile, want.rate_index, want.channel_count,
                           got.kind, got.error_code, got.payload_byte, got.frame_last,
                           got.audio_profile, got.rate_index, got.channel_count));
    endfunction
endclass

module adts_aac_deframer_test;

    localparam logic [1:0] CMD_IGNORED  = 2'd3;
    localparam int         DRAIN_LIMIT  = 100000;
    localparam int         DRAIN_CYCLES = 20;
    localparam int         PHASE_WORDS  = 275;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [1:0] i_command;
    logic [7:0] i_data_byte;
    logic       i_end_of_chunk;
    logic       o_valid;
    logic       i_stall;
    logic       o_kind;
    logic [2:0] o_error_code;
    logic [7:0] o_payload_byte;
    logic       o_frame_last;
    logic [1:0] o_audio_profile;
    logic [3:0] o_rate_index;
    logic [2:0] o_channel_count;

    adts_deframe_predictor predictor;
    t_result               seen;
    logic [7:0]            stream_q [$];
    int                    tx_idle_pct;
    int                    rx_idle_pct;
    int                    words_sent;

    adts_aac_deframer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .i_data_byte     (i_data_byte),
        .i_end_of_chunk  (i_end_of_chunk),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_error_code    (o_error_code),
        .o_payload_byte  (o_payload_byte),
        .o_frame_last    (o_frame_last),
        .o_audio_profile (o_audio_profile),
        .o_rate_index    (o_rate_index),
        .o_channel_count (o_channel_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // check outputs before noting the input taken at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                seen.kind          = o_kind;
                seen.error_code    = o_error_code;
                seen.payload_byte  = o_payload_byte;
                seen.frame_last    = o_frame_last;
                seen.audio_profile = o_audio_profile;
                seen.rate_index    = o_rate_index;
                seen.channel_count = o_channel_count;
                predictor.match_output(seen);
            end
            if (i_valid && !o_stall)
                predictor.take_word(i_command, i_data_byte, i_end_of_chunk);
        end
    end

    task automatic drive_word(logic [1:0] cmd, logic [7:0] b, logic eoc);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_command      <= cmd;
        i_data_byte    <= b;
        i_end_of_chunk <= eoc;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        words_sent++;
    endtask

    function automatic void put_byte(logic [7:0] b);
        stream_q.insert(stream_q.size(), b);
    endfunction

    function automatic void add_frame(logic absent, logic id, logic [1:0] prof,
                                      logic [3:0] rate, logic [2:0] chans, int length,
                                      logic [1:0] blocks, logic [7:0] sync0);
        logic [12:0] len13;
        logic [10:0] fullness;
        int          hsize;
        len13    = length[12:0];
        fullness = 11'($urandom);
        hsize    = absent ? int'(HDR_SIZE_NOCRC) : int'(HDR_SIZE_CRC);
        put_byte(sync0);
        put_byte({SYNC_NIBBLE, id, 2'b00, absent});
        put_byte({prof, rate, 1'($urandom), chans[2]});
        put_byte({chans[1:0], 4'($urandom), len13[12:11]});
        put_byte(len13[10:3]);
        put_byte({len13[2:0], fullness[10:6]});
        put_byte({fullness[5:0], blocks});
        if (!absent) repeat (CRC_BYTES) put_byte(8'($urandom));
        for (int i = hsize; i < length; i++) put_byte(8'($urandom));
    endfunction

    function automatic void add_random_frame();
        logic       absent;
        logic       id;
        logic [1:0] prof;
        logic [3:0] rate;
        logic [2:0] chans;
        logic [1:0] blocks;
        logic [7:0] sync0;
        int         hsize;
        int         length;
        int         pick;
        absent = 1'($urandom);
        id     = 1'($urandom);
        prof   = 2'($urandom_range(2));
        rate   = 4'($urandom_range(11));
        chans  = 3'($urandom_range(7, 1));
        blocks = 2'd0;
        sync0  = SYNC_BYTE;
        hsize  = absent ? int'(HDR_SIZE_NOCRC) : int'(HDR_SIZE_CRC);
        length = hsize + (($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(16));
        pick   = $urandom_range(99);
        if (pick < 4) prof = PROFILE_RESERVED;
        else if (pick < 7) rate = 4'($urandom_range(15, 12));
        else if (pick < 10) chans = 3'd0;
        else if (pick < 14) blocks = 2'($urandom_range(3, 1));
        else if (pick < 18) length = $urandom_range(hsize - 1);
        else if (pick < 21) sync0 = 8'($urandom_range(254));
        add_frame(absent, id, prof, rate, chans, length, blocks, sync0);
    endfunction

    function automatic void add_noise(int count);
        repeat (count) begin
            if ($urandom_range(3) == 0) put_byte(SYNC_BYTE);
            else if ($urandom_range(3) == 0) put_byte({SYNC_NIBBLE, 4'($urandom)});
            else put_byte(8'($urandom));
        end
    endfunction

    task automatic send_stream(logic close_chunk);
        int n;
        n = stream_q.size();
        for (int i = 0; i < n; i++)
            drive_word(CMD_DATA, stream_q[i],
                       (close_chunk && i == n - 1) || ($urandom_range(31) == 0));
        stream_q.delete();
    endtask

    task automatic run_random(int tx_pct, int rx_pct, int count);
        int stop_at;
        int pick;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop_at     = words_sent + count;
        while (words_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                if ($urandom_range(3) == 0) add_noise($urandom_range(4, 1));
                repeat ($urandom_range(3, 1)) add_random_frame();
                send_stream(1'b1);
            end else if (pick < 80) begin
                // cut a frame short, then clear
                add_random_frame();
                repeat ($urandom_range(3, 1)) void'(stream_q.pop_back());
                send_stream(1'b0);
                drive_word($urandom_range(1) ? CMD_CLEAR : CMD_CLEAR_ALL,
                           8'($urandom), 1'($urandom));
            end else if (pick < 90) begin
                add_noise($urandom_range(12, 1));
                send_stream(1'b1);
            end else begin
                pick = $urandom_range(2);
                drive_word(pick == 0 ? CMD_CLEAR : (pick == 1 ? CMD_CLEAR_ALL : CMD_IGNORED),
                           8'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        int waited;
        predictor      = new();
        words_sent     = 0;
        tx_idle_pct    = 38;
        rx_idle_pct    = 82;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_command      <= CMD_DATA;
        i_data_byte    <= 8'd0;
        i_end_of_chunk <= 1'b0;
        i_stall        <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // chunk with no sync
        drive_word(CMD_DATA, 8'h00, 1'b0);
        drive_word(CMD_DATA, SYNC_BYTE, 1'b1);
        // reserved profile, zero channels, top rate index with nothing latched
        add_frame(1'b1, 1'b0, PROFILE_RESERVED, 4'd15, 3'd0, 7, 2'd0, SYNC_BYTE);
        send_stream(1'b1);
        drive_word(CMD_IGNORED, 8'hFF, 1'b1);
        // empty payload, latches the largest legal fields
        add_frame(1'b1, 1'b0, 2'd2, MAX_RATE_INDEX, 3'd7, 7, 2'd0, SYNC_BYTE);
        send_stream(1'b1);
        // CRC frame carrying both extreme payload bytes
        add_frame(1'b0, 1'b1, 2'd1, 4'd3, 3'd2, 11, 2'd0, SYNC_BYTE);
        void'(stream_q.pop_back());
        void'(stream_q.pop_back());
        put_byte(8'h00);
        put_byte(8'hFF);
        send_stream(1'b1);
        drive_word(CMD_CLEAR, 8'h00, 1'b0);
        drive_word(CMD_CLEAR_ALL, 8'hFF, 1'b1);

        run_random(38, 82, PHASE_WORDS);
        run_random(82, 38, PHASE_WORDS);
        run_random(0, 0, PHASE_WORDS);
        i_valid <= 1'b0;

        waited = 0;
        while (predictor.due_outputs.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (predictor.due_outputs.size() != 0)
            predictor.flag($sformatf("%0d output words never arrived",
                                     predictor.due_outputs.size()));
        if (predictor.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
